FILE: hw/rtl/asx_pkg.sv
// ----------------------------------------------------------------------------
// asx_pkg
// Shared codes, defaults and the condition check for the execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

package asx_pkg;

  localparam int MEM_BYTES_DEF = 65536;

  localparam logic [2:0] KIND_PROC = 3'd0;
  localparam logic [2:0] KIND_MUL  = 3'd1;
  localparam logic [2:0] KIND_XFER = 3'd2;
  localparam logic [2:0] KIND_BR   = 3'd3;
  localparam logic [2:0] KIND_HALT = 3'd4;

  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_BOUND = 2'd2;

  localparam int FN = 3;
  localparam int FZ = 2;
  localparam int FC = 1;
  localparam int FV = 0;

  localparam logic [3:0] PC_REG = 4'd15;

  localparam int MB_PRE  = 0;
  localparam int MB_UP   = 1;
  localparam int MB_LOAD = 2;
  localparam int MB_ACC  = 0;

  function automatic logic cond_pass(input logic [3:0] c, input logic [3:0] f);
    logic n, z, cf, v, r;
    n = f[FN];
    z = f[FZ];
    cf = f[FC];
    v = f[FV];
    case (c)
      4'd0:  r = z;
      4'd1:  r = !z;
      4'd2:  r = cf;
      4'd3:  r = !cf;
      4'd4:  r = n;
      4'd5:  r = !n;
      4'd6:  r = v;
      4'd7:  r = !v;
      4'd8:  r = cf && !z;
      4'd9:  r = !cf || z;
      4'd10: r = (n == v);
      4'd11: r = (n != v);
      4'd12: r = !z && (n == v);
      4'd13: r = z || (n != v);
      4'd14: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/arm_subset_execute_stage.sv
// ----------------------------------------------------------------------------
// arm_subset_execute_stage
// Execute stage: condition check, ALU, multiply, word load/store, branch.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one decoded instruction per beat;
// output channel (out_valid/out_stall) carries one result per instruction.
// An accepted beat reads its registers from the register file copies in the
// accept cycle into registers; S_EXEC then executes and writes back. A load that
// reaches memory goes on from S_EXEC to S_LOAD, since the byte-lane data
// memory returns its word registered after the address is formed. A new beat
// is taken only once the stage is back in S_IDLE.
// The result sits in an output register, so the next beat is taken while a
// result waits; when out_stall holds and the output register is full, the
// execute cycle waits (a load still issues its memory read).
// After reset the data memory is cleared one word row per cycle, all ROWS
// rows, with in_stall high; registers and flags read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_subset_execute_stage #(
  parameter int MEM_BYTES = asx_pkg::MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [3:0]  cond,
  input  wire logic [3:0]  opcode,
  input  wire logic [3:0]  dest_reg,
  input  wire logic [3:0]  first_reg,
  input  wire logic [3:0]  shift_reg,
  input  wire logic [3:0]  mult_reg,
  input  wire logic [31:0] operand,
  input  wire logic        shift_carry,
  input  wire logic        set_flags,
  input  wire logic [2:0]  mode_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             executed,
  output logic             flush,
  output logic [1:0]       status,
  output logic [31:0]      result_value,
  output logic [3:0]       flags_out
);
  import asx_pkg::*;

  localparam int          ROWS     = (MEM_BYTES + 3) / 4;
  localparam int          RowW     = $clog2(ROWS);
  localparam logic [31:0] MAX_ADDR = 32'(MEM_BYTES - 4);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0]      phase;
  logic [RowW-1:0] clr_row;
  logic [3:0]      flags;

  // held instruction
  logic [2:0]  kind_q;
  logic [3:0]  cond_q, opc_q, rd_q, rn_q;
  logic [31:0] opnd_q;
  logic        scarry_q, sflag_q;
  logic [2:0]  mode_q;

  // register file: two copies, two read ports each
  logic [31:0] rfa [16];
  logic [31:0] rfb [16];
  logic [15:0] rf_vld;
  logic [31:0] a_val, t_val, s_val, m_val;
  logic [3:0]  rn_addr;

  logic        accept, out_free;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (phase != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign rn_addr  = (kind == KIND_BR) ? PC_REG : first_reg;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      cond_q   <= cond;
      opc_q    <= opcode;
      rd_q     <= dest_reg;
      rn_q     <= rn_addr;
      opnd_q   <= operand;
      scarry_q <= shift_carry;
      sflag_q  <= set_flags;
      mode_q   <= mode_bits;
      a_val    <= rf_vld[rn_addr]   ? rfa[rn_addr]   : '0;
      t_val    <= rf_vld[dest_reg]  ? rfa[dest_reg]  : '0;
      s_val    <= rf_vld[shift_reg] ? rfb[shift_reg] : '0;
      m_val    <= rf_vld[mult_reg]  ? rfb[mult_reg]  : '0;
    end
  end

  // execute
  logic        pass;
  logic [31:0] alu_r, prod, mul_r, moved, addr, br_off, br_r;
  logic [32:0] wide;
  logic        alu_c, alu_ok, alu_wr, in_bounds;

  assign pass = cond_pass(cond_q, flags);

  always_comb begin
    alu_r  = '0;
    alu_c  = scarry_q;
    alu_ok = 1'b1;
    alu_wr = 1'b1;
    wide   = '0;
    case (opc_q)
      OP_AND: alu_r = a_val & opnd_q;
      OP_EOR: alu_r = a_val ^ opnd_q;
      OP_SUB, OP_CMP: begin
        wide   = {1'b0, a_val} + {1'b0, ~opnd_q} + 33'd1;
        alu_r  = wide[31:0];
        alu_c  = wide[32];
        alu_wr = (opc_q == OP_SUB);
      end
      OP_RSB: begin
        wide  = {1'b0, opnd_q} + {1'b0, ~a_val} + 33'd1;
        alu_r = wide[31:0];
        alu_c = wide[32];
      end
      OP_ADD: begin
        wide  = {1'b0, a_val} + {1'b0, opnd_q};
        alu_r = wide[31:0];
        alu_c = wide[32];
      end
      OP_TST: begin
        alu_r  = a_val & opnd_q;
        alu_wr = 1'b0;
      end
      OP_TEQ: begin
        alu_r  = a_val ^ opnd_q;
        alu_wr = 1'b0;
      end
      OP_ORR: alu_r = a_val | opnd_q;
      OP_MOV: alu_r = opnd_q;
      default: alu_ok = 1'b0;
    endcase
  end

  assign prod      = m_val * s_val;
  assign mul_r     = prod + (mode_q[MB_ACC] ? a_val : 32'd0);
  assign moved     = mode_q[MB_UP] ? (a_val + opnd_q) : (a_val - opnd_q);
  assign addr      = mode_q[MB_PRE] ? moved : a_val;
  assign in_bounds = (addr <= MAX_ADDR);
  assign br_off    = {{6{opnd_q[23]}}, opnd_q[23:0], 2'b00};
  assign br_r      = a_val + br_off;

  logic        x_exec, x_flush, x_ldgo, x_wr;
  logic [1:0]  x_status;
  logic [31:0] x_value, x_wdat;
  logic [3:0]  x_flags, x_waddr;
  logic        x_st;

  always_comb begin
    x_exec   = 1'b0;
    x_flush  = 1'b0;
    x_ldgo   = 1'b0;
    x_st     = 1'b0;
    x_status = ST_OK;
    x_value  = '0;
    x_flags  = flags;
    x_wr     = 1'b0;
    x_waddr  = rd_q;
    x_wdat   = '0;
    if (pass) begin
      case (kind_q)
        KIND_PROC: begin
          if (!alu_ok) begin
            x_status = ST_INVAL;
          end else begin
            x_exec  = 1'b1;
            x_value = alu_r;
            x_wr    = alu_wr;
            x_wdat  = alu_r;
            if (sflag_q) begin
              x_flags[FN] = alu_r[31];
              x_flags[FZ] = (alu_r == 32'd0);
              x_flags[FC] = alu_c;
            end
          end
        end
        KIND_MUL: begin
          x_exec  = 1'b1;
          x_value = mul_r;
          x_wr    = 1'b1;
          x_wdat  = mul_r;
          if (sflag_q) begin
            x_flags[FN] = mul_r[31];
            x_flags[FZ] = (mul_r == 32'd0);
          end
        end
        KIND_XFER: begin
          // post-index base write-back happens here; a load writes rd later
          x_wr    = !mode_q[MB_PRE];
          x_waddr = rn_q;
          x_wdat  = moved;
          if (!in_bounds) begin
            x_status = ST_BOUND;
          end else if (mode_q[MB_LOAD]) begin
            x_ldgo = 1'b1;
          end else begin
            x_st    = 1'b1;
            x_exec  = 1'b1;
            x_value = t_val;
          end
        end
        KIND_BR: begin
          x_exec  = 1'b1;
          x_flush = 1'b1;
          x_value = br_r;
          x_wr    = 1'b1;
          x_waddr = PC_REG;
          x_wdat  = br_r;
        end
        KIND_HALT: x_exec = 1'b1;
        default: x_status = ST_INVAL;
      endcase
    end
  end

  logic exec_fire, exec_done, load_done;
  assign exec_fire = (phase == S_EXEC) && (x_ldgo || out_free);
  assign exec_done = (phase == S_EXEC) && !x_ldgo && out_free;
  assign load_done = (phase == S_LOAD) && out_free;

  // data memory: four byte lanes, lane b holds bytes with address[1:0] == b
  logic [1:0]      ld_off;
  logic [3:0]      ld_rd;
  logic [7:0]      lane_q [4];
  logic [RowW-1:0] row_base;
  logic [1:0]      a_off;
  logic [31:0]     ld_word;

  assign row_base = addr[RowW+1:2];
  assign a_off    = addr[1:0];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [7:0]      lane_mem [ROWS];
    logic [RowW-1:0] row;
    logic [1:0]      idx;
    assign row = row_base + RowW'(2'(g) < a_off);
    assign idx = 2'(g) - a_off;
    always_ff @(posedge clk) begin
      if (phase == S_CLEAR) begin
        lane_mem[clr_row] <= 8'd0;
      end else if (exec_fire && x_st) begin
        lane_mem[row] <= t_val[8*idx +: 8];
      end
      if (exec_fire && x_ldgo) begin
        lane_q[g] <= lane_mem[row];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_word[8*i +: 8] = lane_q[2'(i) + ld_off];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && x_ldgo) begin
      ld_off <= a_off;
      ld_rd  <= rd_q;
    end
  end

  // register file write: one per edge
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_dat;
  assign wr_en   = (exec_fire && x_wr) || load_done;
  assign wr_addr = load_done ? ld_rd : x_waddr;
  assign wr_dat  = load_done ? ld_word : x_wdat;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rfa[wr_addr] <= wr_dat;
      rfb[wr_addr] <= wr_dat;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= S_CLEAR;
      clr_row   <= '0;
      flags     <= '0;
      rf_vld    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) rf_vld[wr_addr] <= 1'b1;
      if (exec_done) flags <= x_flags;
      if (exec_done || load_done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (phase)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == RowW'(ROWS - 1)) phase <= S_IDLE;
        end
        S_IDLE: if (accept) phase <= S_EXEC;
        S_EXEC: begin
          if (x_ldgo) begin
            phase <= S_LOAD;
          end else if (out_free) begin
            phase <= S_IDLE;
          end
        end
        S_LOAD: if (out_free) phase <= S_IDLE;
        default: phase <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      executed     <= x_exec;
      flush        <= x_flush;
      status       <= x_status;
      result_value <= x_value;
      flags_out    <= x_flags;
    end else if (load_done) begin
      executed     <= 1'b1;
      flush        <= 1'b0;
      status       <= ST_OK;
      result_value <= ld_word;
      flags_out    <= flags;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (phase == S_EXEC))
    else $error("accepted beat did not enter execute");

  a_load_entry: assert property (@(posedge clk) disable iff (rst)
    (phase == S_LOAD) |-> ($past(phase) == S_LOAD || $past(phase) == S_EXEC))
    else $error("load wait entered from wrong phase");

  a_flush_exec: assert property (@(posedge clk) disable iff (rst)
    (out_valid && flush) |-> executed)
    else $error("flush without execution");

  a_fault_noexec: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> !executed)
    else $error("faulted result marked executed");

endmodule

`default_nettype wire

FILE: dv/tb_arm_subset_execute_stage.sv
// ----------------------------------------------------------------------------
// tb_arm_subset_execute_stage
// Self-checking bench for the execute stage: a local copy of the register
// file, flags and data memory predicts every result, which is compared field
// by field against the output beats under several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_arm_subset_execute_stage;
  timeunit 1ns;
  timeprecision 1ps;
  import asx_pkg::*;

  localparam int MEM_SIZE = MEM_BYTES_DEF;
  localparam int LIMIT_CYCLES = 1500000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  cond;
    logic [3:0]  opcode;
    logic [3:0]  rd;
    logic [3:0]  rn;
    logic [3:0]  rs;
    logic [3:0]  rm;
    logic [31:0] operand;
    logic        scarry;
    logic        sflag;
    logic [2:0]  mode;
  } instr_t;

  typedef struct packed {
    logic        executed;
    logic        flush;
    logic [1:0]  status;
    logic [31:0] value;
    logic [3:0]  flags;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0]  kind = '0;
  logic [3:0]  cond = '0;
  logic [3:0]  opcode = '0;
  logic [3:0]  dest_reg = '0;
  logic [3:0]  first_reg = '0;
  logic [3:0]  shift_reg = '0;
  logic [3:0]  mult_reg = '0;
  logic [31:0] operand = '0;
  logic        shift_carry = 1'b0;
  logic        set_flags = 1'b0;
  logic [2:0]  mode_bits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic        executed;
  logic        flush;
  logic [1:0]  status;
  logic [31:0] result_value;
  logic [3:0]  flags_out;

  arm_subset_execute_stage dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .cond(cond), .opcode(opcode), .dest_reg(dest_reg),
    .first_reg(first_reg), .shift_reg(shift_reg), .mult_reg(mult_reg),
    .operand(operand), .shift_carry(shift_carry), .set_flags(set_flags),
    .mode_bits(mode_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .executed(executed), .flush(flush), .status(status),
    .result_value(result_value), .flags_out(flags_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow machine state
  logic [31:0] shadow_regs [16];
  logic [3:0]  shadow_flags;
  logic [7:0]  shadow_mem [MEM_SIZE];
  outcome_t    pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic outcome_t execute_instr(input instr_t ins);
    outcome_t o;
    logic [31:0] a, r, base, tval, moved, addr, off;
    logic [32:0] sum;
    logic c, wr, ok;
    logic [3:0] f;
    o = '0;
    f = shadow_flags;
    if (cond_pass(ins.cond, f)) begin
      case (ins.kind)
        KIND_PROC: begin
          a = shadow_regs[ins.rn];
          c = ins.scarry;
          wr = 1'b1;
          ok = 1'b1;
          r = '0;
          case (ins.opcode)
            OP_AND: r = a & ins.operand;
            OP_EOR: r = a ^ ins.operand;
            OP_SUB: begin r = a - ins.operand; c = a >= ins.operand; end
            OP_RSB: begin r = ins.operand - a; c = ins.operand >= a; end
            OP_ADD: begin
              sum = {1'b0, a} + {1'b0, ins.operand};
              r = sum[31:0];
              c = sum[32];
            end
            OP_TST: begin r = a & ins.operand; wr = 1'b0; end
            OP_TEQ: begin r = a ^ ins.operand; wr = 1'b0; end
            OP_CMP: begin r = a - ins.operand; c = a >= ins.operand; wr = 1'b0; end
            OP_ORR: r = a | ins.operand;
            OP_MOV: r = ins.operand;
            default: ok = 1'b0;
          endcase
          if (!ok) begin
            o.status = ST_INVAL;
          end else begin
            if (wr) shadow_regs[ins.rd] = r;
            if (ins.sflag) begin
              f[FN] = r[31];
              f[FZ] = (r == 0);
              f[FC] = c;
            end
            o.value = r;
            o.executed = 1'b1;
          end
        end
        KIND_MUL: begin
          r = shadow_regs[ins.rm] * shadow_regs[ins.rs];
          if (ins.mode[MB_ACC]) r = r + shadow_regs[ins.rn];
          shadow_regs[ins.rd] = r;
          if (ins.sflag) begin
            f[FN] = r[31];
            f[FZ] = (r == 0);
          end
          o.value = r;
          o.executed = 1'b1;
        end
        KIND_XFER: begin
          base = shadow_regs[ins.rn];
          tval = shadow_regs[ins.rd];
          moved = ins.mode[MB_UP] ? base + ins.operand : base - ins.operand;
          if (ins.mode[MB_PRE]) begin
            addr = moved;
          end else begin
            addr = base;
            shadow_regs[ins.rn] = moved;
          end
          if ({32'd0, addr} + 64'd4 > 64'(MEM_SIZE)) begin
            o.status = ST_BOUND;
          end else if (ins.mode[MB_LOAD]) begin
            r = {shadow_mem[addr + 3], shadow_mem[addr + 2],
                 shadow_mem[addr + 1], shadow_mem[addr]};
            shadow_regs[ins.rd] = r;
            o.value = r;
            o.executed = 1'b1;
          end else begin
            for (int i = 0; i < 4; i++) shadow_mem[addr + i] = tval[8*i +: 8];
            o.value = tval;
            o.executed = 1'b1;
          end
        end
        KIND_BR: begin
          off = {{6{ins.operand[23]}}, ins.operand[23:0], 2'b00};
          shadow_regs[PC_REG] = shadow_regs[PC_REG] + off;
          o.value = shadow_regs[PC_REG];
          o.flush = 1'b1;
          o.executed = 1'b1;
        end
        KIND_HALT: o.executed = 1'b1;
        default: o.status = ST_INVAL;
      endcase
    end
    shadow_flags = f;
    o.flags = f;
    return o;
  endfunction

  // drive one beat; hold it until accepted
  task automatic send_instr(input instr_t ins);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= ins.kind; cond <= ins.cond; opcode <= ins.opcode;
    dest_reg <= ins.rd; first_reg <= ins.rn; shift_reg <= ins.rs;
    mult_reg <= ins.rm; operand <= ins.operand; shift_carry <= ins.scarry;
    set_flags <= ins.sflag; mode_bits <= ins.mode;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(execute_instr(ins));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    outcome_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result_value, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (executed !== want.executed)
          report_mismatch("executed", 32'(executed), 32'(want.executed));
        if (flush !== want.flush)
          report_mismatch("flush", 32'(flush), 32'(want.flush));
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (result_value !== want.value) report_mismatch("value", result_value, want.value);
        if (flags_out !== want.flags)
          report_mismatch("flags", 32'(flags_out), 32'(want.flags));
      end
    end
  end

  function automatic instr_t make_instr(input logic [2:0] k, input logic [3:0] c,
                                        input logic [3:0] op, input logic [3:0] rd,
                                        input logic [3:0] rn, input logic [31:0] val,
                                        input logic s, input logic [2:0] m);
    instr_t ins;
    ins = '0;
    ins.kind = k; ins.cond = c; ins.opcode = op; ins.rd = rd; ins.rn = rn;
    ins.rs = rn; ins.rm = rd; ins.operand = val; ins.sflag = s; ins.mode = m;
    return ins;
  endfunction

  function automatic instr_t rand_instr();
    instr_t ins;
    int pick;
    ins = instr_t'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 90) ins.kind = (pick < 40) ? KIND_PROC : (pick < 55) ? KIND_MUL :
                             (pick < 82) ? KIND_XFER : (pick < 87) ? KIND_BR : KIND_HALT;
    if ($urandom_range(3) != 0) ins.cond = 4'd14;
    if (ins.kind == KIND_PROC && $urandom_range(9) != 0) begin
      case ($urandom_range(9))
        0: ins.opcode = OP_AND; 1: ins.opcode = OP_EOR; 2: ins.opcode = OP_SUB;
        3: ins.opcode = OP_RSB; 4: ins.opcode = OP_ADD; 5: ins.opcode = OP_TST;
        6: ins.opcode = OP_TEQ; 7: ins.opcode = OP_CMP; 8: ins.opcode = OP_ORR;
        default: ins.opcode = OP_MOV;
      endcase
    end
    // keep most transfers near the low memory window so loads see stores
    if (ins.kind == KIND_XFER && $urandom_range(4) != 0) begin
      ins.operand = $urandom_range(64);
      if ($urandom_range(2) == 0) ins.rn = 4'd0;
    end
    if (ins.kind == KIND_PROC && ins.opcode == OP_MOV && $urandom_range(1) == 0)
      ins.operand = $urandom_range(MEM_SIZE + 8);
    return ins;
  endfunction

  task automatic wait_drain();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_alu();
    send_instr(make_instr(KIND_PROC, 4'd14, OP_MOV, 4'd1, 4'd0, 32'hFFFF_FFFF, 1'b1, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd14, OP_ADD, 4'd2, 4'd1, 32'd1, 1'b1, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd14, OP_SUB, 4'd3, 4'd1, 32'hFFFF_FFFF, 1'b1, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd14, OP_RSB, 4'd4, 4'd1, 32'd0, 1'b1, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd14, OP_AND, 4'd5, 4'd1, 32'h8000_0000, 1'b1, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd14, OP_EOR, 4'd6, 4'd1, 32'h5555_AAAA, 1'b0, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd14, OP_TST, 4'd7, 4'd1, 32'd0, 1'b1, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd0, OP_ORR, 4'd7, 4'd1, 32'h1234, 1'b0, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd14, OP_TEQ, 4'd7, 4'd1, 32'hFFFF_FFFF, 1'b0, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd14, OP_CMP, 4'd7, 4'd2, 32'd1, 1'b1, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd14, 4'd5, 4'd7, 4'd1, 32'd3, 1'b1, 3'd0));
    send_instr(make_instr(KIND_PROC, 4'd15, OP_MOV, 4'd7, 4'd1, 32'd3, 1'b1, 3'd0));
    send_instr(make_instr(3'd7, 4'd14, OP_MOV, 4'd7, 4'd1, 32'd3, 1'b1, 3'd0));
  endtask

  task automatic test_directed_mem_branch();
    send_instr(make_instr(KIND_MUL, 4'd14, OP_AND, 4'd8, 4'd1, 32'd0, 1'b1, 3'd1));
    send_instr(make_instr(KIND_PROC, 4'd14, OP_MOV, 4'd9, 4'd0, MEM_SIZE - 4, 1'b0, 3'd0));
    send_instr(make_instr(KIND_XFER, 4'd14, OP_AND, 4'd1, 4'd9, 32'd0, 1'b0, 3'd1));
    send_instr(make_instr(KIND_XFER, 4'd14, OP_AND, 4'd10, 4'd9, 32'd0, 1'b0, 3'd5));
    send_instr(make_instr(KIND_XFER, 4'd14, OP_AND, 4'd10, 4'd9, 32'd1, 1'b0, 3'd7));
    send_instr(make_instr(KIND_XFER, 4'd14, OP_AND, 4'd9, 4'd9, 32'd3, 1'b0, 3'd2));
    send_instr(make_instr(KIND_XFER, 4'd14, OP_AND, 4'd9, 4'd9, 32'd3, 1'b0, 3'd4));
    send_instr(make_instr(KIND_BR, 4'd14, OP_AND, 4'd0, 4'd0, 32'hFF80_0000, 1'b0, 3'd0));
    send_instr(make_instr(KIND_BR, 4'd14, OP_AND, 4'd0, 4'd0, 32'h007F_FFFF, 1'b0, 3'd0));
    send_instr(make_instr(KIND_HALT, 4'd14, OP_AND, 4'd0, 4'd0, 32'd0, 1'b0, 3'd0));
  endtask

  task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_instr(rand_instr());
    // drop valid and hold off until everything has returned
    in_valid <= 1'b0;
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < 16; i++) shadow_regs[i] = '0;
    shadow_flags = '0;
    for (int i = 0; i < MEM_SIZE; i++) shadow_mem[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_alu();
    test_directed_mem_branch();
    test_random_phase(250, 0, 0);
    test_random_phase(250, 60, 0);
    test_random_phase(250, 0, 60);
    test_random_phase(250, 16, 16);
    recv_stall_pct = 0;
    wait_drain();
    repeat (20) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: arm_subset_execute_stage.f
hw/rtl/asx_pkg.sv
hw/rtl/arm_subset_execute_stage.sv
dv/tb_arm_subset_execute_stage.sv
